// File: design/mips_subset_execute_stage_defines.svh
// ---------------------------------------------------------------------------
// assertion macros for the mips subset execute stage
// ---------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_STAGE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_STAGE_DEFINES_SVH

`ifndef SYNTHESIS
`define MSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MSE_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSE_ASSERT(lbl, clk, rstn, prop, msg)
`define MSE_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

// File: design/mse_pkg.sv
// ---------------------------------------------------------------------------
// mse_pkg
// types and opcode constants shared by the execute stage
// ---------------------------------------------------------------------------
package mse_pkg;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLTU = 6'd43;

  localparam logic [4:0]  LINK_REG     = 5'd31;
  localparam logic [4:0]  ZERO_REG     = 5'd0;
  localparam logic [31:0] PC_HIGH_MASK = 32'hF000_0000;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [4:0]  shift_amount;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [15:0] immediate;
    logic [31:0] next_pc;
    logic [25:0] jump_index;
    logic [4:0]  dest_reg;
  } in_item_t;

  typedef struct packed {
    logic [31:0] alu_result;
    logic        write_enable;
    logic [4:0]  write_reg;
    logic [31:0] store_data;
    logic        mem_read;
    logic        mem_write;
    logic        branch_taken;
    logic        redirect;
    logic [31:0] redirect_pc;
  } out_item_t;

endpackage

// File: design/mse_in_if.sv
// ---------------------------------------------------------------------------
// mse_in_if
// valid/ready channel carrying one decoded instruction
// ---------------------------------------------------------------------------
interface mse_in_if;
  logic              valid;
  logic              ready;
  logic [5:0]        opcode;
  logic [5:0]        funct;
  logic [4:0]        shift_amount;
  logic [31:0]       rs_value;
  logic [31:0]       rt_value;
  logic signed [15:0] immediate;
  logic [31:0]       next_pc;
  logic [25:0]       jump_index;
  logic [4:0]        dest_reg;

  modport source (
    output valid, opcode, funct, shift_amount, rs_value, rt_value, immediate,
           next_pc, jump_index, dest_reg,
    input  ready
  );
  modport sink (
    input  valid, opcode, funct, shift_amount, rs_value, rt_value, immediate,
           next_pc, jump_index, dest_reg,
    output ready
  );
endinterface

// File: design/mse_out_if.sv
// ---------------------------------------------------------------------------
// mse_out_if
// valid/ready channel carrying one execute result
// ---------------------------------------------------------------------------
interface mse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] alu_result;
  logic        write_enable;
  logic [4:0]  write_reg;
  logic [31:0] store_data;
  logic        mem_read;
  logic        mem_write;
  logic        branch_taken;
  logic        redirect;
  logic [31:0] redirect_pc;

  modport source (
    output valid, alu_result, write_enable, write_reg, store_data, mem_read,
           mem_write, branch_taken, redirect, redirect_pc,
    input  ready
  );
  modport sink (
    input  valid, alu_result, write_enable, write_reg, store_data, mem_read,
           mem_write, branch_taken, redirect, redirect_pc,
    output ready
  );
endinterface

// File: design/mse_in_stage.sv
// ---------------------------------------------------------------------------
// mse_in_stage
// input register: while downstream is ready, captures one instruction per cycle
// ---------------------------------------------------------------------------
module mse_in_stage
  import mse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mse_in_if.sink     in_ch,
  input  logic       down_ready,
  output logic       item_valid,
  output in_item_t   item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign in_ch.ready = !valid_r || down_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.opcode       <= in_ch.opcode;
      item_r.funct        <= in_ch.funct;
      item_r.shift_amount <= in_ch.shift_amount;
      item_r.rs_value     <= in_ch.rs_value;
      item_r.rt_value     <= in_ch.rt_value;
      item_r.immediate    <= in_ch.immediate;
      item_r.next_pc      <= in_ch.next_pc;
      item_r.jump_index   <= in_ch.jump_index;
      item_r.dest_reg     <= in_ch.dest_reg;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: design/mse_exec.sv
// ---------------------------------------------------------------------------
// mse_exec
// decode and compute: alu, address generation, branch and jump targets
// ---------------------------------------------------------------------------
module mse_exec
  import mse_pkg::*;
(
  input  in_item_t  item,
  output out_item_t res
);

  logic [31:0] sext;
  logic [31:0] zext;
  logic [31:0] jtarget;
  logic [31:0] btarget;
  logic [31:0] agen;
  logic [31:0] alu;
  logic [31:0] rpc;
  logic [31:0] sdata;
  logic [4:0]  wreg;
  logic        we;
  logic        mr;
  logic        mw;
  logic        bt;
  logic        rd;

  assign sext    = {{16{item.immediate[15]}}, item.immediate};
  assign zext    = {16'h0000, item.immediate};
  assign jtarget = (item.next_pc & PC_HIGH_MASK) | {4'h0, item.jump_index, 2'b00};
  assign btarget = item.next_pc + {sext[29:0], 2'b00};
  assign agen    = item.rs_value + sext;

  always_comb begin
    alu   = '0;
    rpc   = '0;
    sdata = '0;
    wreg  = ZERO_REG;
    we    = 1'b0;
    mr    = 1'b0;
    mw    = 1'b0;
    bt    = 1'b0;
    rd    = 1'b0;
    unique case (item.opcode)
      OP_RTYPE: begin
        wreg = item.dest_reg;
        we   = 1'b1;
        unique case (item.funct)
          FN_SLL:  alu = item.rt_value << item.shift_amount;
          FN_SRL:  alu = item.rt_value >> item.shift_amount;
          FN_ADDU: alu = item.rs_value + item.rt_value;
          FN_SUBU: alu = item.rs_value - item.rt_value;
          FN_AND:  alu = item.rs_value & item.rt_value;
          FN_OR:   alu = item.rs_value | item.rt_value;
          FN_NOR:  alu = ~(item.rs_value | item.rt_value);
          FN_SLTU: alu = {31'd0, item.rs_value < item.rt_value};
          FN_JR: begin
            we  = 1'b0;
            rd  = 1'b1;
            rpc = item.rs_value;
          end
          default: we = 1'b0;
        endcase
      end
      OP_J: begin
        rd  = 1'b1;
        rpc = jtarget;
      end
      OP_JAL: begin
        rd   = 1'b1;
        rpc  = jtarget;
        alu  = item.next_pc;
        we   = 1'b1;
        wreg = LINK_REG;
      end
      OP_BEQ: bt = (item.rs_value == item.rt_value);
      OP_BNE: bt = (item.rs_value != item.rt_value);
      OP_ADDIU: begin
        alu  = agen;
        we   = 1'b1;
        wreg = item.dest_reg;
      end
      OP_SLTIU: begin
        alu  = {31'd0, item.rs_value < sext};
        we   = 1'b1;
        wreg = item.dest_reg;
      end
      OP_ANDI: begin
        alu  = item.rs_value & zext;
        we   = 1'b1;
        wreg = item.dest_reg;
      end
      OP_ORI: begin
        alu  = item.rs_value | zext;
        we   = 1'b1;
        wreg = item.dest_reg;
      end
      OP_LUI: begin
        alu  = {item.immediate, 16'h0000};
        we   = 1'b1;
        wreg = item.dest_reg;
      end
      OP_LW: begin
        alu  = agen;
        mr   = 1'b1;
        we   = 1'b1;
        wreg = item.dest_reg;
      end
      OP_SW: begin
        alu   = agen;
        mw    = 1'b1;
        sdata = item.rt_value;
      end
      default: ;
    endcase
    if (bt) begin
      rd  = 1'b1;
      rpc = btarget;
    end
    // writes to r0 vanish
    if (!we || wreg == ZERO_REG) begin
      we   = 1'b0;
      wreg = ZERO_REG;
    end
  end

  assign res.alu_result   = alu;
  assign res.write_enable = we;
  assign res.write_reg    = wreg;
  assign res.store_data   = sdata;
  assign res.mem_read     = mr;
  assign res.mem_write    = mw;
  assign res.branch_taken = bt;
  assign res.redirect     = rd;
  assign res.redirect_pc  = rpc;

endmodule

// File: design/mse_out_stage.sv
// ---------------------------------------------------------------------------
// mse_out_stage
// result register driving the output channel
// ---------------------------------------------------------------------------
`include "mips_subset_execute_stage_defines.svh"

module mse_out_stage
  import mse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  out_item_t  res,
  output logic       up_ready,
  mse_out_if.source  out_ch
);

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  logic      load;

  assign up_ready = !out_valid_r || out_ch.ready;
  assign load     = item_valid && up_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (up_ready) begin
      out_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.alu_result   = out_item_r.alu_result;
  assign out_ch.write_enable = out_item_r.write_enable;
  assign out_ch.write_reg    = out_item_r.write_reg;
  assign out_ch.store_data   = out_item_r.store_data;
  assign out_ch.mem_read     = out_item_r.mem_read;
  assign out_ch.mem_write    = out_item_r.mem_write;
  assign out_ch.branch_taken = out_item_r.branch_taken;
  assign out_ch.redirect     = out_item_r.redirect;
  assign out_ch.redirect_pc  = out_item_r.redirect_pc;

  `MSE_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid_r, "result valid after reset")
  `MSE_ASSERT(a_no_r0_write, clk, rst_n, out_valid_r && out_item_r.write_enable |-> out_item_r.write_reg != ZERO_REG, "write to r0 reported")
  `MSE_ASSERT(a_idle_wreg, clk, rst_n, out_valid_r && !out_item_r.write_enable |-> out_item_r.write_reg == ZERO_REG, "write_reg set without write")
  `MSE_ASSERT(a_mem_excl, clk, rst_n, out_valid_r |-> !(out_item_r.mem_read && out_item_r.mem_write), "load and store at once")
  `MSE_ASSERT(a_branch_redir, clk, rst_n, out_valid_r && out_item_r.branch_taken |-> out_item_r.redirect, "taken branch without redirect")
  `MSE_ASSERT(a_redir_pc, clk, rst_n, out_valid_r && !out_item_r.redirect |-> out_item_r.redirect_pc == '0, "redirect_pc set without redirect")

endmodule

// File: design/mips_subset_execute_stage.sv
// ---------------------------------------------------------------------------
// mips_subset_execute_stage: an item passes the input register and then the result register after accept
// throughput one item per cycle while out_ch.ready is high: input register, one pass of alu logic, result register
// in_ch.ready follows out_ch.ready combinationally through both register stages
// rst_n (synchronous) empties both stages; no other state
// ---------------------------------------------------------------------------
module mips_subset_execute_stage
  import mse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mse_in_if.sink    in_ch,
  mse_out_if.source out_ch
);

  in_item_t  item;
  out_item_t res;
  logic      item_valid;
  logic      out_ready;

  mse_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .down_ready (out_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  mse_exec u_exec (
    .item (item),
    .res  (res)
  );

  mse_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .up_ready   (out_ready),
    .out_ch     (out_ch)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: execute stage testbench
// drives decoded instructions into the execute stage over a valid/ready
// channel, predicts each result from the instruction fields alone and
// compares every result field in order, in most phases with random idling on both sides
// ---------------------------------------------------------------------------
module tb_top;
  import mse_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 500;

  logic clk = 1'b0;
  logic rst_n;

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  mips_subset_execute_stage DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  out_item_t   expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 63;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, expected_results.size());
      $display("[mips_subset_execute_stage] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // expected result of one instruction, fields without meaning held at zero
  function automatic out_item_t predict_execute(input in_item_t ins);
    out_item_t   r;
    logic [31:0] imm_sx;
    logic [31:0] imm_zx;
    logic [31:0] jump_pc;
    logic        wr;
    r       = '0;
    wr      = 1'b0;
    imm_sx  = {{16{ins.immediate[15]}}, ins.immediate};
    imm_zx  = {16'h0000, ins.immediate};
    jump_pc = (ins.next_pc & PC_HIGH_MASK) | {4'h0, ins.jump_index, 2'b00};
    if (ins.opcode == OP_RTYPE) begin
      wr          = 1'b1;
      r.write_reg = ins.dest_reg;
      case (ins.funct)
        FN_SLL:  r.alu_result = ins.rt_value << ins.shift_amount;
        FN_SRL:  r.alu_result = ins.rt_value >> ins.shift_amount;
        FN_ADDU: r.alu_result = ins.rs_value + ins.rt_value;
        FN_SUBU: r.alu_result = ins.rs_value - ins.rt_value;
        FN_AND:  r.alu_result = ins.rs_value & ins.rt_value;
        FN_OR:   r.alu_result = ins.rs_value | ins.rt_value;
        FN_NOR:  r.alu_result = ~(ins.rs_value | ins.rt_value);
        FN_SLTU: r.alu_result = {31'b0, ins.rs_value < ins.rt_value};
        FN_JR: begin
          wr            = 1'b0;
          r.redirect    = 1'b1;
          r.redirect_pc = ins.rs_value;
        end
        default: wr = 1'b0;
      endcase
    end else begin
      case (ins.opcode)
        OP_J: begin
          r.redirect    = 1'b1;
          r.redirect_pc = jump_pc;
        end
        OP_JAL: begin
          r.redirect    = 1'b1;
          r.redirect_pc = jump_pc;
          r.alu_result  = ins.next_pc;
          r.write_reg   = LINK_REG;
          wr            = 1'b1;
        end
        OP_BEQ: r.branch_taken = (ins.rs_value == ins.rt_value);
        OP_BNE: r.branch_taken = (ins.rs_value != ins.rt_value);
        OP_ADDIU: begin
          r.alu_result = ins.rs_value + imm_sx;
          r.write_reg  = ins.dest_reg;
          wr           = 1'b1;
        end
        OP_SLTIU: begin
          r.alu_result = {31'b0, ins.rs_value < imm_sx};
          r.write_reg  = ins.dest_reg;
          wr           = 1'b1;
        end
        OP_ANDI: begin
          r.alu_result = ins.rs_value & imm_zx;
          r.write_reg  = ins.dest_reg;
          wr           = 1'b1;
        end
        OP_ORI: begin
          r.alu_result = ins.rs_value | imm_zx;
          r.write_reg  = ins.dest_reg;
          wr           = 1'b1;
        end
        OP_LUI: begin
          r.alu_result = {ins.immediate, 16'h0000};
          r.write_reg  = ins.dest_reg;
          wr           = 1'b1;
        end
        OP_LW: begin
          r.alu_result = ins.rs_value + imm_sx;
          r.mem_read   = 1'b1;
          r.write_reg  = ins.dest_reg;
          wr           = 1'b1;
        end
        OP_SW: begin
          r.alu_result = ins.rs_value + imm_sx;
          r.mem_write  = 1'b1;
          r.store_data = ins.rt_value;
        end
        default: ;
      endcase
      if (r.branch_taken) begin
        r.redirect    = 1'b1;
        r.redirect_pc = ins.next_pc + {imm_sx[29:0], 2'b00};
      end
    end
    // writes aimed at register zero are dropped
    if (!wr || r.write_reg == ZERO_REG) begin
      r.write_enable = 1'b0;
      r.write_reg    = ZERO_REG;
    end else begin
      r.write_enable = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // results are checked before the item accepted in the same cycle is queued
  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    in_item_t  accepted;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.alu_result, out_ch.write_enable, out_ch.write_reg,
               out_ch.store_data, out_ch.mem_read, out_ch.mem_write,
               out_ch.branch_taken, out_ch.redirect, out_ch.redirect_pc};
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none got %h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("alu_result", want.alu_result, got.alu_result);
          check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
          check_field("write_reg", 32'(want.write_reg), 32'(got.write_reg));
          check_field("store_data", want.store_data, got.store_data);
          check_field("mem_read", 32'(want.mem_read), 32'(got.mem_read));
          check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
          check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
          check_field("redirect", 32'(want.redirect), 32'(got.redirect));
          check_field("redirect_pc", want.redirect_pc, got.redirect_pc);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        accepted = {in_ch.opcode, in_ch.funct, in_ch.shift_amount, in_ch.rs_value,
                    in_ch.rt_value, in_ch.immediate, in_ch.next_pc,
                    in_ch.jump_index, in_ch.dest_reg};
        expected_results.push_back(predict_execute(accepted));
      end
    end
  end

  // called right after a rising edge; returns at the edge that accepts the item
  task automatic send_instr(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= it.opcode;
    in_ch.funct        <= it.funct;
    in_ch.shift_amount <= it.shift_amount;
    in_ch.rs_value     <= it.rs_value;
    in_ch.rt_value     <= it.rt_value;
    in_ch.immediate    <= it.immediate;
    in_ch.next_pc      <= it.next_pc;
    in_ch.jump_index   <= it.jump_index;
    in_ch.dest_reg     <= it.dest_reg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // holds the sender off until every pending result has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    @(posedge clk);
  endtask

  function automatic in_item_t make_instr(
    input logic [5:0] op, input logic [5:0] fn, input logic [4:0] sh,
    input logic [31:0] rs, input logic [31:0] rt, input logic [15:0] imm,
    input logic [31:0] npc, input logic [25:0] jidx, input logic [4:0] dst);
    in_item_t it;
    it = {op, fn, sh, rs, rt, imm, npc, jidx, dst};
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_instr();
    in_item_t    it;
    int unsigned pick;
    it.opcode       = OP_RTYPE;
    it.funct        = 6'($urandom_range(63));
    it.shift_amount = 5'($urandom_range(31));
    it.rs_value     = rand_word();
    it.rt_value     = rand_word();
    it.immediate    = 16'($urandom_range(16'hFFFF));
    it.next_pc      = rand_word();
    it.jump_index   = 26'($urandom_range(26'h3FF_FFFF));
    it.dest_reg     = 5'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.opcode = 6'($urandom_range(63));
    end else if (pick < 45) begin
      // a few r-type items keep a random funct
      if (pick >= 11) begin
        case ($urandom_range(8))
          0: it.funct = FN_SLL;
          1: it.funct = FN_SRL;
          2: it.funct = FN_JR;
          3: it.funct = FN_ADDU;
          4: it.funct = FN_SUBU;
          5: it.funct = FN_AND;
          6: it.funct = FN_OR;
          7: it.funct = FN_NOR;
          default: it.funct = FN_SLTU;
        endcase
      end
    end else begin
      case ($urandom_range(10))
        0: it.opcode = OP_J;
        1: it.opcode = OP_JAL;
        2: it.opcode = OP_BEQ;
        3: it.opcode = OP_BNE;
        4: it.opcode = OP_ADDIU;
        5: it.opcode = OP_SLTIU;
        6: it.opcode = OP_ANDI;
        7: it.opcode = OP_ORI;
        8: it.opcode = OP_LUI;
        9: it.opcode = OP_LW;
        default: it.opcode = OP_SW;
      endcase
    end
    // give branches an even chance of being taken
    if ((it.opcode == OP_BEQ || it.opcode == OP_BNE) && $urandom_range(1))
      it.rt_value = it.rs_value;
    return it;
  endfunction

  task automatic test_register_ops();
    send_instr(make_instr(OP_RTYPE, FN_ADDU, 5'd7, 32'hFFFF_FFFF, 32'h1, 16'h1234,
                          32'h0040_0004, 26'h155_5555, 5'd31));
    send_instr(make_instr(OP_RTYPE, FN_SUBU, 5'd0, 32'h0, 32'h1, 16'hFFFF,
                          32'hFFFF_FFFC, 26'h0, 5'd1));
    send_instr(make_instr(OP_RTYPE, FN_AND, 5'd31, 32'hA5A5_A5A5, 32'hFFFF_0000, 16'h0,
                          32'h0, 26'h3FF_FFFF, 5'd2));
    send_instr(make_instr(OP_RTYPE, FN_OR, 5'd0, 32'h8000_0000, 32'h0000_0001, 16'h8000,
                          32'h1000_0000, 26'h0, 5'd3));
    send_instr(make_instr(OP_RTYPE, FN_NOR, 5'd0, 32'h0, 32'h0, 16'h0,
                          32'h0, 26'h0, 5'd4));
    send_instr(make_instr(OP_RTYPE, FN_SLTU, 5'd0, 32'h1, 32'hFFFF_FFFF, 16'h0,
                          32'h0, 26'h0, 5'd5));
    send_instr(make_instr(OP_RTYPE, FN_SLTU, 5'd0, 32'hFFFF_FFFF, 32'h1, 16'h0,
                          32'h0, 26'h0, 5'd6));
    // write to register zero is dropped
    send_instr(make_instr(OP_RTYPE, FN_ADDU, 5'd0, 32'h1234_5678, 32'h1, 16'h0,
                          32'h0, 26'h0, ZERO_REG));
  endtask

  task automatic test_shifts();
    send_instr(make_instr(OP_RTYPE, FN_SLL, 5'd31, 32'hFFFF_FFFF, 32'h0000_0003, 16'h0,
                          32'h0, 26'h0, 5'd8));
    send_instr(make_instr(OP_RTYPE, FN_SRL, 5'd31, 32'h0, 32'h8000_0000, 16'h0,
                          32'h0, 26'h0, 5'd9));
  endtask

  task automatic test_immediate_ops();
    send_instr(make_instr(OP_ADDIU, 6'd63, 5'd31, 32'h0, 32'hFFFF_FFFF, 16'h8000,
                          32'h0, 26'h0, 5'd10));
    send_instr(make_instr(OP_SLTIU, 6'd0, 5'd0, 32'hFFFF_FFFE, 32'h0, 16'hFFFF,
                          32'h0, 26'h0, 5'd11));
    // andi and ori zero-extend
    send_instr(make_instr(OP_ANDI, 6'd0, 5'd0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF,
                          32'h0, 26'h0, 5'd12));
    send_instr(make_instr(OP_ORI, 6'd0, 5'd0, 32'h0, 32'h0, 16'h8000,
                          32'h0, 26'h0, 5'd13));
    send_instr(make_instr(OP_LUI, 6'd0, 5'd0, 32'hFFFF_FFFF, 32'h0, 16'hFFFF,
                          32'h0, 26'h0, 5'd31));
  endtask

  task automatic test_load_store();
    send_instr(make_instr(OP_LW, 6'd0, 5'd0, 32'h0000_1000, 32'h0, 16'hFFFC,
                          32'h0, 26'h0, 5'd14));
    send_instr(make_instr(OP_SW, 6'd0, 5'd0, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 16'h7FFF,
                          32'h0, 26'h0, 5'd15));
  endtask

  task automatic test_branches();
    // taken with the most negative offset wraps below zero
    send_instr(make_instr(OP_BEQ, 6'd0, 5'd0, 32'h5555_5555, 32'h5555_5555, 16'h8000,
                          32'h0000_0010, 26'h0, 5'd16));
    send_instr(make_instr(OP_BEQ, 6'd0, 5'd0, 32'h5555_5555, 32'h5555_5554, 16'h0004,
                          32'h0000_0010, 26'h0, 5'd17));
    send_instr(make_instr(OP_BNE, 6'd0, 5'd0, 32'h0, 32'hFFFF_FFFF, 16'h7FFF,
                          32'hFFFF_FFF0, 26'h0, 5'd18));
    send_instr(make_instr(OP_BNE, 6'd0, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF,
                          32'h0000_0100, 26'h0, 5'd19));
  endtask

  task automatic test_jumps();
    send_instr(make_instr(OP_J, 6'd0, 5'd0, 32'h0, 32'h0, 16'h0,
                          32'hFFFF_FFFF, 26'h3FF_FFFF, 5'd20));
    // jal keeps the upper pc bits and links into r31
    send_instr(make_instr(OP_JAL, 6'd0, 5'd0, 32'h0, 32'h0, 16'h0,
                          32'hA000_0004, 26'h0, 5'd21));
    send_instr(make_instr(OP_RTYPE, FN_JR, 5'd0, 32'hFFFF_FFFF, 32'h0, 16'h0,
                          32'h0, 26'h0, 5'd22));
  endtask

  task automatic test_undefined_codes();
    send_instr(make_instr(6'd63, 6'd63, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                          32'hFFFF_FFFF, 26'h3FF_FFFF, 5'd31));
    send_instr(make_instr(OP_RTYPE, 6'd63, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                          32'hFFFF_FFFF, 26'h3FF_FFFF, 5'd31));
  endtask

  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_instr(rand_instr());
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= '0;
    in_ch.funct        <= '0;
    in_ch.shift_amount <= '0;
    in_ch.rs_value     <= '0;
    in_ch.rt_value     <= '0;
    in_ch.immediate    <= '0;
    in_ch.next_pc      <= '0;
    in_ch.jump_index   <= '0;
    in_ch.dest_reg     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_ops();
    test_shifts();
    test_immediate_ops();
    test_load_store();
    test_branches();
    test_jumps();
    test_undefined_codes();
    test_random_mix(RANDOM_ITEMS / 3);
    wait_for_results();

    send_idle_pct = 63;
    recv_idle_pct = 34;
    test_random_mix(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[mips_subset_execute_stage] OK");
    end else begin
      $display("[mips_subset_execute_stage] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/mse_pkg.sv
design/mse_in_if.sv
design/mse_out_if.sv
design/mse_in_stage.sv
design/mse_exec.sv
design/mse_out_stage.sv
design/mips_subset_execute_stage.sv
tb/tb_top.sv
